/* sv/eic_pkg.sv */
// Shared types and codes for the exclusive clutch interlock.
// No dependencies; imported by exclusive_clutch_interlock.
package eic_pkg;

  localparam int PinBits = 4;

  typedef enum logic [2:0] {
    MODE_TICK        = 3'd0,
    MODE_ENGAGE      = 3'd1,
    MODE_RELEASE     = 3'd2,
    MODE_RELEASE_ALL = 3'd3,
    MODE_REL_SETTLED = 3'd4,
    MODE_CHECK       = 3'd5,
    MODE_CLEAR       = 3'd6
  } mode_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BADCH    = 3'd1,
    ST_BUSY     = 3'd2,
    ST_CONFLICT = 3'd3,
    ST_SEVERAL  = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'b0001,
    PH_VERIFY  = 4'b0010,
    PH_BITE    = 4'b0100,
    PH_RELWAIT = 4'b1000
  } phase_e;

  typedef enum logic [1:0] {
    REG_ACTIVE_LEVEL  = 2'd0,
    REG_RELEASE_TICKS = 2'd1,
    REG_SETTLE_TICKS  = 2'd2,
    REG_ENGAGE_TICKS  = 2'd3
  } reg_idx_e;

endpackage

/* sv/exclusive_clutch_interlock.sv */
// Break-before-make interlock for up to four clutch coils.
// Path: an accepted word is held in the input register, then goes through the
//   next-state logic into the result register.
// Throughput: one word per cycle; the input register and the result register
//   each hand over on the same edge, so only a stalled result holds input.
// Reset: asynchronous, active low; all coils off, no channel, counter zero,
//   idle, registers at their defaults. No clearing pass is needed.
// Depends on eic_pkg.
module exclusive_clutch_interlock
  import eic_pkg::*;
#(
  parameter int CHANNELS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input word channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  mode_i,
  input  logic [3:0]  channel_i,
  input  logic [3:0]  sense_levels_i,
  input  logic        drop_multi_i,
  // result word channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  pin_levels_o,
  output logic        halt_motor_o,
  output logic        done_res_o,
  output logic [2:0]  status_o,
  output logic [2:0]  current_channel_o,
  output logic [31:0] conflicts_o,
  output logic        sequencing_o,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Only four pin bits exist, so channels above four are never usable.
  localparam int UsedCh = (CHANNELS < PinBits) ? CHANNELS : PinBits;
  localparam logic [3:0] ChMask = 4'((1 << UsedCh) - 1);
  localparam logic [3:0] ChMax  = 4'(UsedCh);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic        active_level_q;
  logic [15:0] release_ticks_q, settle_ticks_q, engage_ticks_q;
  reg_idx_e    reg_idx;
  logic        cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_level_q  <= 1'b1;
      release_ticks_q <= 16'd100;
      settle_ticks_q  <= 16'd50;
      engage_ticks_q  <= 16'd100;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_ACTIVE_LEVEL:  active_level_q  <= pwdata[0];
        REG_RELEASE_TICKS: release_ticks_q <= pwdata[15:0];
        REG_SETTLE_TICKS:  settle_ticks_q  <= pwdata[15:0];
        REG_ENGAGE_TICKS:  engage_ticks_q  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ACTIVE_LEVEL:  prdata = {31'd0, active_level_q};
      REG_RELEASE_TICKS: prdata = {16'd0, release_ticks_q};
      REG_SETTLE_TICKS:  prdata = {16'd0, settle_ticks_q};
      REG_ENGAGE_TICKS:  prdata = {16'd0, engage_ticks_q};
      default:           prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Handshake: input register feeds the result register
  // ---------------------------------------------------------------------------
  logic       in_vld_q, out_vld_q, adv;
  logic [2:0] in_mode_q;
  logic [3:0] in_ch_q, in_sense_q;
  logic       in_force_q;

  // A held word advances whenever the result register is empty or being drained.
  assign adv        = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_mode_q  <= mode_i;
      in_ch_q    <= channel_i;
      in_sense_q <= sense_levels_i;
      in_force_q <= drop_multi_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Interlock state
  // ---------------------------------------------------------------------------
  logic [3:0]  drive_q, drive_d;
  logic [2:0]  active_q, active_d;
  logic [31:0] conf_q, conf_d;
  phase_e      phase_q, phase_d;
  logic [16:0] wait_q, wait_d;
  logic [2:0]  pend_ch_q, pend_ch_d;
  status_e     pend_st_q, pend_st_d;

  logic [3:0]  eng;
  logic        ch_ok, busy, ch_eng, mstop, done;
  logic [1:0]  ch_idx;
  logic [3:0]  ch_m1;
  status_e     st;
  logic [2:0]  first;
  logic [3:0]  pins;

  assign eng    = (active_level_q ? in_sense_q : ~in_sense_q) & ChMask;
  assign ch_ok  = (in_ch_q >= 4'd1) && (in_ch_q <= ChMax);
  assign ch_m1  = in_ch_q - 4'd1;
  assign ch_idx = ch_m1[1:0];
  assign ch_eng = eng[ch_idx];
  assign busy   = (phase_q != PH_IDLE);

  // Lowest engaged coil, numbered from one.
  always_comb begin
    first = 3'd0;
    for (int i = PinBits - 1; i >= 0; i--) begin
      if (eng[i]) first = 3'(i + 1);
    end
  end

  always_comb begin
    logic [1:0] pend_idx;
    drive_d   = drive_q;
    active_d  = active_q;
    conf_d    = conf_q;
    phase_d   = phase_q;
    wait_d    = wait_q;
    pend_ch_d = pend_ch_q;
    pend_st_d = pend_st_q;
    mstop     = 1'b0;
    done      = 1'b0;
    st        = ST_OK;
    pend_idx  = 2'(pend_ch_q - 3'd1);

    unique case (in_mode_q)
      MODE_TICK: begin
        if (busy) begin
          if (wait_q > 17'd1) begin
            wait_d = wait_q - 17'd1;
          end else if (phase_q == PH_VERIFY) begin
            if (eng != 4'd0) begin
              // A coil still reads on after the quiet time: drop everything.
              conf_d   = conf_q + 32'd1;
              drive_d  = 4'd0;
              active_d = 3'd0;
              phase_d  = PH_IDLE;
              wait_d   = 17'd0;
              done     = 1'b1;
              st       = ST_CONFLICT;
            end else begin
              drive_d = (4'd1 << pend_idx) & ChMask;
              phase_d = PH_BITE;
              wait_d  = {1'b0, engage_ticks_q};
            end
          end else if (phase_q == PH_BITE) begin
            active_d = pend_ch_q;
            phase_d  = PH_IDLE;
            wait_d   = 17'd0;
            done     = 1'b1;
          end else begin
            phase_d = PH_IDLE;
            wait_d  = 17'd0;
            done    = 1'b1;
            st      = pend_st_q;
          end
        end
      end
      MODE_ENGAGE: begin
        done = 1'b1;
        if (!ch_ok) begin
          st = ST_BADCH;
        end else if (busy) begin
          st = ST_BUSY;
        end else if (({1'b0, active_q} == in_ch_q) && ch_eng) begin
          st = ST_OK;
        end else begin
          // Break first: stop the motor, drop all coils (or, if none reads on, drive the new one).
          mstop     = 1'b1;
          active_d  = 3'd0;
          pend_ch_d = in_ch_q[2:0];
          done      = 1'b0;
          if (eng != 4'd0) begin
            drive_d = 4'd0;
            phase_d = PH_VERIFY;
            wait_d  = {1'b0, release_ticks_q} + {1'b0, settle_ticks_q};
          end else begin
            drive_d = (4'd1 << ch_idx) & ChMask;
            phase_d = PH_BITE;
            wait_d  = {1'b0, engage_ticks_q};
          end
        end
      end
      MODE_RELEASE: begin
        done = 1'b1;
        if (!ch_ok) begin
          st = ST_BADCH;
        end else if (!ch_eng) begin
          st = ST_OK;
        end else if (busy) begin
          st = ST_BUSY;
        end else begin
          pend_st_d = ST_OK;
          if ({1'b0, active_q} != in_ch_q) begin
            conf_d    = conf_q + 32'd1;
            pend_st_d = ST_CONFLICT;
          end
          mstop    = 1'b1;
          drive_d  = 4'd0;
          active_d = 3'd0;
          phase_d  = PH_RELWAIT;
          wait_d   = {1'b0, release_ticks_q};
          done     = 1'b0;
        end
      end
      MODE_RELEASE_ALL, MODE_REL_SETTLED: begin
        done = 1'b1;
        if (busy) begin
          st = ST_BUSY;
        end else begin
          mstop    = 1'b1;
          drive_d  = 4'd0;
          active_d = 3'd0;
          if (in_mode_q == MODE_REL_SETTLED) begin
            pend_st_d = ST_OK;
            phase_d   = PH_RELWAIT;
            wait_d    = {1'b0, release_ticks_q};
            done      = 1'b0;
          end
        end
      end
      MODE_CHECK: begin
        done = 1'b1;
        if (busy) begin
          st = ST_BUSY;
        end else if ((eng & (eng - 4'd1)) != 4'd0) begin
          conf_d = conf_q + 32'd1;
          st     = ST_SEVERAL;
          if (in_force_q) begin
            mstop    = 1'b1;
            drive_d  = 4'd0;
            active_d = 3'd0;
          end
        end else begin
          active_d = first;
        end
      end
      MODE_CLEAR: begin
        done = 1'b1;
        if (busy) st = ST_BUSY;
        else conf_d = 32'd0;
      end
      default: ;
    endcase
  end

  // Off coils get the inverse of the active level.
  assign pins = active_level_q ? (drive_d & ChMask) : ~drive_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drive_q   <= 4'd0;
      active_q  <= 3'd0;
      conf_q    <= 32'd0;
      phase_q   <= PH_IDLE;
      wait_q    <= 17'd0;
      pend_ch_q <= 3'd0;
      pend_st_q <= ST_OK;
    end else if (adv) begin
      drive_q   <= drive_d;
      active_q  <= active_d;
      conf_q    <= conf_d;
      phase_q   <= phase_d;
      wait_q    <= wait_d;
      pend_ch_q <= pend_ch_d;
      pend_st_q <= pend_st_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pin_levels_o      <= pins;
      halt_motor_o      <= mstop;
      done_res_o        <= done;
      status_o          <= done ? st : ST_OK;
      current_channel_o <= active_d;
      conflicts_o       <= conf_d;
      sequencing_o      <= (phase_d != PH_IDLE);
    end
  end

  assign out_valid_o = out_vld_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_one_coil: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(drive_q))
    else $error("more than one coil driven");

  a_no_owner_in_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_IDLE) |-> (active_q == 3'd0))
    else $error("channel marked engaged while a sequence runs");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_vld_q && out_stall_i))
    else $error("input stalled without a stalled result");

  a_adv_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_vld_q)
    else $error("advanced word did not reach the result register");

endmodule

/* dv/tb_exclusive_clutch_interlock.sv */
// Self-checking bench for exclusive_clutch_interlock: commands and ticks go in,
// each result word is checked against an in-bench model of the interlock.
// Depends on eic_pkg and exclusive_clutch_interlock; nothing else.
module tb_exclusive_clutch_interlock
  import eic_pkg::*;
();

  localparam int NumCh = 4;
  localparam int UsedCh = (NumCh < PinBits) ? NumCh : PinBits;
  localparam logic [3:0] ChMask = 4'((1 << UsedCh) - 1);
  // mode code the block leaves unused
  localparam logic [2:0] ModeUnused = 3'd7;

  typedef struct packed {
    logic [2:0] mode;
    logic [3:0] channel;
    logic [3:0] sense_levels;
    logic       drop_multi;
  } word_t;

  typedef struct packed {
    logic [3:0]  pin_levels;
    logic        halt_motor;
    logic        done_res;
    logic [2:0]  status;
    logic [2:0]  current_channel;
    logic [31:0] conflicts;
    logic        sequencing;
  } result_t;

  // Interlock model plus the queue of result words still owed by the block.
  class interlock_tracker;
    bit          active_level;
    logic [15:0] release_ticks;
    logic [15:0] settle_ticks;
    logic [15:0] engage_ticks;
    logic [3:0]  drive_bits;
    logic [2:0]  active_chan;
    logic [31:0] conflict_total;
    phase_e      phase;
    logic [16:0] wait_count;
    logic [2:0]  pending_chan;
    status_e     pending_status;
    result_t     owed_results[$];
    int          errors;
    int          checked;
    int          noted;

    function new();
      active_level   = 1'b1;
      release_ticks  = 16'd100;
      settle_ticks   = 16'd50;
      engage_ticks   = 16'd100;
      drive_bits     = '0;
      active_chan    = '0;
      conflict_total = '0;
      phase          = PH_IDLE;
      wait_count     = '0;
      pending_chan   = '0;
      pending_status = ST_OK;
      errors         = 0;
      checked        = 0;
      noted          = 0;
    endfunction

    function void set_register(reg_idx_e idx, logic [31:0] value);
      case (idx)
        REG_ACTIVE_LEVEL:  active_level  = value[0];
        REG_RELEASE_TICKS: release_ticks = value[15:0];
        REG_SETTLE_TICKS:  settle_ticks  = value[15:0];
        REG_ENGAGE_TICKS:  engage_ticks  = value[15:0];
        default: ;
      endcase
    endfunction

    function logic [3:0] pin_image();
      return active_level ? (drive_bits & ChMask) : ~drive_bits;
    endfunction

    function bit sequencing();
      return phase != PH_IDLE;
    endfunction

    function int outstanding();
      return owed_results.size();
    endfunction

    function void drop_all();
      drive_bits  = '0;
      active_chan = '0;
    endfunction

    // Advance the model by one word and return the result word it yields.
    function result_t step_interlock(word_t w);
      logic [3:0] eng;
      logic [2:0] first;
      bit         busy;
      bit         ch_ok;
      bit         mstop;
      bit         done;
      status_e    st;
      int         cnt;
      result_t    r;
      eng   = (active_level ? w.sense_levels : ~w.sense_levels) & ChMask;
      busy  = phase != PH_IDLE;
      ch_ok = (w.channel >= 4'd1) && (w.channel <= 4'(UsedCh));
      mstop = 1'b0;
      done  = 1'b0;
      st    = ST_OK;
      case (w.mode)
        MODE_TICK: begin
          if (busy) begin
            if (wait_count > 17'd1) begin
              wait_count--;
            end else if (phase == PH_VERIFY) begin
              if (eng != '0) begin
                conflict_total++;
                drop_all();
                phase      = PH_IDLE;
                wait_count = '0;
                done       = 1'b1;
                st         = ST_CONFLICT;
              end else begin
                drive_bits = (4'b0001 << 2'(pending_chan - 3'd1)) & ChMask;
                phase      = PH_BITE;
                wait_count = {1'b0, engage_ticks};
              end
            end else if (phase == PH_BITE) begin
              active_chan = pending_chan;
              phase       = PH_IDLE;
              wait_count  = '0;
              done        = 1'b1;
            end else begin
              phase      = PH_IDLE;
              wait_count = '0;
              done       = 1'b1;
              st         = pending_status;
            end
          end
        end
        MODE_ENGAGE: begin
          done = 1'b1;
          if (!ch_ok) begin
            st = ST_BADCH;
          end else if (busy) begin
            st = ST_BUSY;
          end else if (active_chan == w.channel && eng[w.channel - 4'd1]) begin
            st = ST_OK;
          end else begin
            mstop = 1'b1;
            drop_all();
            pending_chan = w.channel[2:0];
            done = 1'b0;
            if (eng != '0) begin
              phase      = PH_VERIFY;
              wait_count = {1'b0, release_ticks} + {1'b0, settle_ticks};
            end else begin
              drive_bits = (4'b0001 << (w.channel - 4'd1)) & ChMask;
              phase      = PH_BITE;
              wait_count = {1'b0, engage_ticks};
            end
          end
        end
        MODE_RELEASE: begin
          done = 1'b1;
          if (!ch_ok) begin
            st = ST_BADCH;
          end else if (!eng[w.channel - 4'd1]) begin
            st = ST_OK;
          end else if (busy) begin
            st = ST_BUSY;
          end else begin
            pending_status = ST_OK;
            if (active_chan != w.channel) begin
              conflict_total++;
              pending_status = ST_CONFLICT;
            end
            mstop = 1'b1;
            drop_all();
            phase      = PH_RELWAIT;
            wait_count = {1'b0, release_ticks};
            done       = 1'b0;
          end
        end
        MODE_RELEASE_ALL, MODE_REL_SETTLED: begin
          done = 1'b1;
          if (busy) begin
            st = ST_BUSY;
          end else begin
            mstop = 1'b1;
            drop_all();
            if (w.mode == MODE_REL_SETTLED) begin
              pending_status = ST_OK;
              phase          = PH_RELWAIT;
              wait_count     = {1'b0, release_ticks};
              done           = 1'b0;
            end
          end
        end
        MODE_CHECK: begin
          done = 1'b1;
          if (busy) begin
            st = ST_BUSY;
          end else begin
            cnt   = 0;
            first = '0;
            for (int i = 0; i < PinBits; i++) begin
              if (eng[i]) begin
                cnt++;
                if (first == '0) first = 3'(i + 1);
              end
            end
            if (cnt > 1) begin
              conflict_total++;
              st = ST_SEVERAL;
              if (w.drop_multi) begin
                mstop = 1'b1;
                drop_all();
              end
            end else begin
              active_chan = first;
            end
          end
        end
        MODE_CLEAR: begin
          done = 1'b1;
          if (busy) st = ST_BUSY;
          else conflict_total = '0;
        end
        default: ;
      endcase
      r.pin_levels      = pin_image();
      r.halt_motor      = mstop;
      r.done_res        = done;
      r.status          = done ? st : ST_OK;
      r.current_channel = active_chan;
      r.conflicts       = conflict_total;
      r.sequencing      = phase != PH_IDLE;
      return r;
    endfunction

    function void note_word(word_t w);
      owed_results.push_back(step_interlock(w));
      noted++;
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_word(result_t got);
      result_t want;
      if (owed_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word, expected none actual %h", $time, got);
        return;
      end
      want = owed_results.pop_front();
      checked++;
      compare_field("pin_levels", want.pin_levels, got.pin_levels);
      compare_field("halt_motor", want.halt_motor, got.halt_motor);
      compare_field("done_res", want.done_res, got.done_res);
      compare_field("status", want.status, got.status);
      compare_field("current_channel", want.current_channel, got.current_channel);
      compare_field("conflicts", want.conflicts, got.conflicts);
      compare_field("sequencing", want.sequencing, got.sequencing);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [2:0]  mode_i;
  logic [3:0]  channel_i;
  logic [3:0]  sense_levels_i;
  logic        drop_multi_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [3:0]  pin_levels_o;
  logic        halt_motor_o;
  logic        done_res_o;
  logic [2:0]  status_o;
  logic [2:0]  current_channel_o;
  logic [31:0] conflicts_o;
  logic        sequencing_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  interlock_tracker sb = new();
  // calm: both sides stop idling (back-to-back words, no result stall)
  bit calm;
  int reg_writes;
  int ph;
  int k;

  exclusive_clutch_interlock #(
    .CHANNELS(NumCh)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .mode_i           (mode_i),
    .channel_i        (channel_i),
    .sense_levels_i   (sense_levels_i),
    .drop_multi_i     (drop_multi_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .pin_levels_o     (pin_levels_o),
    .halt_motor_o     (halt_motor_o),
    .done_res_o       (done_res_o),
    .status_o         (status_o),
    .current_channel_o(current_channel_o),
    .conflicts_o      (conflicts_o),
    .sequencing_o     (sequencing_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always #5 clk_i = ~clk_i;

  // Check every result word at the edge it is taken.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_word('{pin_levels_o, halt_motor_o, done_res_o, status_o,
                      current_channel_o, conflicts_o, sequencing_o});
    end
  end

  // Result side: raise stall at random (never while calm), then
  // drop it until the next result word is taken.
  initial begin : result_stall
    int n;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      n = calm ? 0 : $urandom_range(0, 7);
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Hard stop: far beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("[exclusive_clutch_interlock] ERROR");
    $finish;
  end

  function automatic word_t mk(logic [2:0] m, logic [3:0] c, logic [3:0] s, logic f);
    word_t w;
    w.mode         = m;
    w.channel      = c;
    w.sense_levels = s;
    w.drop_multi   = f;
    return w;
  endfunction

  // Send one word: idle a random gap, present the word, hold it while stalled.
  // Starts and ends at a falling edge; valid stays high after acceptance so a
  // following word with no gap goes out back to back.
  task automatic send_word(word_t w);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    mode_i         <= w.mode;
    channel_i      <= w.channel;
    sense_levels_i <= w.sense_levels;
    drop_multi_i   <= w.drop_multi;
    in_valid_i     <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_word(w);
    @(negedge clk_i);
  endtask

  // Drop valid and wait until every owed result word has come back.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Setup and access cycle, then psel drops so the next write starts clean.
  task automatic apb_write(reg_idx_e idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_register(idx, value);
    reg_writes++;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  // Reprogram all four registers once every owed result word is back.
  task automatic program_regs(bit level, logic [15:0] rel, logic [15:0] settle,
                              logic [15:0] bite);
    drain();
    apb_write(REG_ACTIVE_LEVEL, {31'd0, level});
    apb_write(REG_RELEASE_TICKS, {16'd0, rel});
    apb_write(REG_SETTLE_TICKS, {16'd0, settle});
    apb_write(REG_ENGAGE_TICKS, {16'd0, bite});
  endtask

  // Mostly commands plus ticks, coils mostly following what the block drives,
  // with some noise on sense levels and bad channel numbers.
  function automatic word_t random_word();
    word_t w;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) w.mode = MODE_TICK;
    else if (pick < 65) w.mode = MODE_ENGAGE;
    else if (pick < 75) w.mode = MODE_RELEASE;
    else if (pick < 80) w.mode = MODE_RELEASE_ALL;
    else if (pick < 85) w.mode = MODE_REL_SETTLED;
    else if (pick < 93) w.mode = MODE_CHECK;
    else if (pick < 97) w.mode = MODE_CLEAR;
    else w.mode = ModeUnused;
    w.channel = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(1, UsedCh));
    w.sense_levels = ($urandom_range(0, 9) < 7) ? sb.pin_image() : 4'($urandom);
    w.drop_multi   = 1'($urandom);
    return w;
  endfunction

  // Directed pass: verify window of one tick, zero engage time (acts as one).
  task automatic run_directed();
    program_regs(1'b1, 16'd1, 16'd0, 16'd0);
    send_word(mk(MODE_TICK, 4'd0, 4'b0000, 1'b0));        // tick with nothing running
    send_word(mk(ModeUnused, 4'hF, 4'hF, 1'b1));          // unused mode: no effect
    send_word(mk(MODE_CHECK, 4'd0, 4'b0000, 1'b0));       // all off
    send_word(mk(MODE_CHECK, 4'd0, 4'b0100, 1'b0));       // one on: adopt channel 3
    send_word(mk(MODE_CHECK, 4'd0, 4'b1010, 1'b0));       // several on, left alone
    send_word(mk(MODE_CHECK, 4'd0, 4'b1111, 1'b1));       // several on, forced off
    send_word(mk(MODE_CLEAR, 4'd0, 4'b0000, 1'b0));
    send_word(mk(MODE_ENGAGE, 4'd0, 4'b0000, 1'b0));      // bad channels
    send_word(mk(MODE_ENGAGE, 4'hF, 4'b0000, 1'b0));
    send_word(mk(MODE_RELEASE, 4'd5, 4'b0000, 1'b0));
    send_word(mk(MODE_ENGAGE, 4'd1, 4'b0000, 1'b0));      // nothing on: straight to bite
    send_word(mk(MODE_TICK, 4'd0, 4'b0000, 1'b0));
    send_word(mk(MODE_ENGAGE, 4'd1, 4'b0001, 1'b0));      // repeat engage
    send_word(mk(MODE_ENGAGE, 4'd4, 4'b0001, 1'b0));      // coil on: verify window
    send_word(mk(MODE_ENGAGE, 4'd2, 4'b0000, 1'b0));      // busy
    send_word(mk(MODE_RELEASE, 4'd3, 4'b0000, 1'b0));     // not engaged: ok ahead of busy
    send_word(mk(MODE_RELEASE, 4'd1, 4'b0001, 1'b0));     // busy
    send_word(mk(MODE_RELEASE_ALL, 4'd0, 4'b0000, 1'b0)); // busy
    send_word(mk(MODE_CHECK, 4'd0, 4'b0000, 1'b0));       // busy
    send_word(mk(MODE_TICK, 4'd0, 4'b0000, 1'b0));        // all off: drive channel 4
    send_word(mk(MODE_TICK, 4'd0, 4'b1000, 1'b0));        // bite done
    send_word(mk(MODE_ENGAGE, 4'd2, 4'b1000, 1'b0));
    send_word(mk(MODE_TICK, 4'd0, 4'b1000, 1'b0));        // coil stuck on: conflict
    send_word(mk(MODE_RELEASE, 4'd2, 4'b0010, 1'b0));     // not the owner: conflict later
    send_word(mk(MODE_TICK, 4'd0, 4'b0000, 1'b0));
    send_word(mk(MODE_REL_SETTLED, 4'd0, 4'b0000, 1'b0));
    send_word(mk(MODE_CLEAR, 4'd0, 4'b0000, 1'b0));       // busy
    send_word(mk(MODE_TICK, 4'd0, 4'b0000, 1'b0));
  endtask

  // Long waits with inverted polarity: a full verify window then a full
  // bite window, sent back to back.
  task automatic run_long_waits();
    program_regs(1'b0, 16'd40, 16'd25, 16'd30);
    calm = 1'b1;
    send_word(mk(MODE_ENGAGE, 4'd2, 4'b1110, 1'b0));
    while (sb.sequencing()) send_word(mk(MODE_TICK, 4'd0, sb.pin_image(), 1'b0));
    calm = 1'b0;
  endtask

  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    mode_i         = '0;
    channel_i      = '0;
    sense_levels_i = '0;
    drop_multi_i   = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    calm           = 1'b0;
    reg_writes     = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    run_directed();

    // Random phases, each under its own register setting.
    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: program_regs(1'b1, 16'd0, 16'd0, 16'd0);
        1: program_regs(1'b0, 16'd3, 16'd2, 16'd4);
        2: program_regs(1'b1, 16'd1, 16'd0, 16'd2);
        default: program_regs(1'($urandom), 16'($urandom_range(0, 6)),
                              16'($urandom_range(0, 6)), 16'($urandom_range(0, 6)));
      endcase
      calm = (ph == 2);
      repeat (180) begin
        send_word(random_word());
        // now and then hold the sender until every result is back
        if ($urandom_range(0, 59) == 0) drain();
      end
    end

    run_long_waits();

    in_valid_i <= 1'b0;
    for (k = 0; k < 2000 && sb.outstanding() != 0; k++) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    if (sb.outstanding() != 0) begin
      sb.errors++;
      $display("%0t: results never arrived, expected %0d more actual 0",
               $time, sb.outstanding());
    end

    $display("Sent %0d words (directed, six random settings, a long verify and",
             sb.noted);
    $display("bite window); checked %0d results after %0d register writes.",
             sb.checked, reg_writes);
    if (sb.errors == 0) begin
      $display("[exclusive_clutch_interlock] OK");
    end else begin
      $display("[exclusive_clutch_interlock] ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/eic_pkg.sv
sv/exclusive_clutch_interlock.sv
dv/tb_exclusive_clutch_interlock.sv
